/* rtl/core/hbe_pkg.sv */
// hbe_pkg: shared types and constants of the huffman build and encode block
// used by huffman_build_and_encode and its port checker; no dependencies
package hbe_pkg;

  localparam int unsigned SYMBOLS      = 256;
  localparam int unsigned NODES        = 2 * SYMBOLS - 1;
  localparam int unsigned MAX_CODE_LEN = 48;
  localparam int unsigned LEN_LIMIT    = (MAX_CODE_LEN < 49) ? MAX_CODE_LEN : 49;
  localparam int unsigned NODE_W       = $clog2(NODES);
  localparam int unsigned SYM_W        = $clog2(SYMBOLS);
  localparam int unsigned LEN_W        = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned DEPTH_W      = 8;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned LIMIT_W      = 31;

  typedef enum logic [2:0] {
    REQ_COUNT = 3'd0,
    REQ_BUILD = 3'd1,
    REQ_LIST  = 3'd2,
    REQ_ENC   = 3'd3,
    REQ_FLUSH = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    KIND_LIST  = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_TOTAL = 2'd2,
    KIND_ERR   = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CNT_RD,
    S_CNT_WR,
    S_SRT_RD,
    S_SRT_CHK,
    S_SH_RD,
    S_SH_CMP,
    S_SH_PUT,
    S_SRT_END,
    S_MG_RD,
    S_MG_PICK,
    S_MG_WR,
    S_CG_ROOT,
    S_CG_RD,
    S_CG_W0,
    S_CG_W1,
    S_FL_RD,
    S_FL_CHK,
    S_LST_RD,
    S_LST_OUT,
    S_ENC_RD,
    S_ENC_CHK,
    S_ENC_BIT,
    S_ENC_EMIT,
    S_FLU_BYTE,
    S_FLU_TOT,
    S_RES
  } state_e;

endpackage

/* rtl/core/huffman_build_and_encode.sv */
// huffman_build_and_encode: two-pass byte huffman compressor, top level
// histogram, tree build, code table and bit packer under one sequencer; uses hbe_pkg
//
// channel  dir  handshake             payload
// in       in   in_valid_i/in_stall_o  req_type_i, in_byte_i
// out      out  out_valid_o/out_stall_i kind_o, symbol_o, word_o, last_o
// cfg      in   cfg_valid_i/cfg_ready_o cfg_data_i (out_limit)
//
// count: a read, then a write back, through one histogram memory port per word
// encode: one code bit per cycle, pausing to emit each completed code byte, which
//   waits while the output register is stalled
// build: insertion sort of used symbols, a read and a compare per shifted entry,
//   then two picks and a write per merge, a read and two child writes per internal node
// async active-low reset; the block stalls its input whenever busy and waits
//   on a stalled output register before emitting the next word
module huffman_build_and_encode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  req_type_i,
  input  logic [7:0]                  in_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [7:0]                  symbol_o,
  output logic [31:0]                 word_o,
  output logic                        last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [hbe_pkg::LIMIT_W-1:0] cfg_data_i
);
  import hbe_pkg::*;

  // memories
  logic [COUNT_W-1:0]      hist_mem [SYMBOLS];
  logic [31:0]             wt_mem   [NODES];
  logic [SYM_W-1:0]        sym_mem  [SYMBOLS];
  logic [2*NODE_W-1:0]     kid_mem  [NODES];
  logic [MAX_CODE_LEN-1:0] nc_mem   [NODES];
  logic [DEPTH_W-1:0]      nl_mem   [NODES];
  logic [MAX_CODE_LEN-1:0] cb_mem   [SYMBOLS];
  logic [LEN_W-1:0]        cl_mem   [SYMBOLS];

  logic [SYMBOLS-1:0] hv_q, cv_q;

  state_e st_q, st_d;

  logic [SYM_W-1:0]        byte_q, s_q, j_q;
  logic [NODE_W-1:0]       n_q, lq_q, mq_q, k_q, a_q, b_q, i_q, cur_q;
  logic [COUNT_W-1:0]      h_q, wa_q, wb_q;
  logic                    second_q, built_q;
  logic [7:0]              acc_q;
  logic [2:0]              pos_q;
  logic [31:0]             tot_q, bout_q;
  logic [LIMIT_W-1:0]      limit_q;
  logic [MAX_CODE_LEN-1:0] ecode_q;
  logic [LEN_W-1:0]        bi_q;
  logic [2:0]              ecomp_q;
  kind_e                   rk_q;
  logic [31:0]             rw_q;

  // registered read data
  logic [COUNT_W-1:0]      hist_rd_q;
  logic                    hist_hit_q;
  logic [31:0]             wt_rd0_q, wt_rd1_q;
  logic [SYM_W-1:0]        sym_rd_q;
  logic [2*NODE_W-1:0]     kid_rd_q;
  logic [MAX_CODE_LEN-1:0] nc_rd_q, cb_rd_q;
  logic [DEPTH_W-1:0]      nl_rd_q;
  logic [LEN_W-1:0]        cl_rd_q;
  logic                    cv_rd_q;

  // memory controls
  logic [SYM_W-1:0]        hist_ra, sym_ra, sym_wa;
  logic                    hist_we, wt_we, sym_we, kid_we, nc_we, cb_we;
  logic [COUNT_W-1:0]      hist_wd;
  logic [NODE_W-1:0]       wt_ra0, wt_ra1, wt_wa, kid_ra, nc_ra, nc_wa;
  logic [31:0]             wt_wd;
  logic [SYM_W-1:0]        sym_wd;
  logic [MAX_CODE_LEN-1:0] nc_wd;
  logic [DEPTH_W-1:0]      nl_wd;
  logic                    cv_clr;

  // output emit request
  logic        emit, out_free, ov_q;
  kind_e       e_kind;
  logic [7:0]  e_sym;
  logic [31:0] e_word;
  logic        e_last;

  // shared datapath values
  logic               in_acc;
  logic [COUNT_W-1:0] hval;
  logic               take_l;
  logic [NODE_W-1:0]  pick_idx;
  logic [31:0]        pick_w;
  logic [32:0]        msum;
  logic [NODE_W:0]    last_k;
  logic [LEN_W-1:0]   bsum;
  logic [2:0]         comp;
  logic [32:0]        bneed;
  logic [32:0]        tsum;
  logic               enc_ok;
  logic               flush_err;
  logic [LEN_W-1:0]   bi_m1;

  assign in_stall_o  = (st_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !ov_q || !out_stall_i;

  assign hval     = hist_hit_q ? hist_rd_q : '0;
  assign take_l   = (lq_q < n_q) && (!(mq_q < k_q) || (wt_rd0_q <= wt_rd1_q));
  assign pick_idx = take_l ? lq_q : mq_q;
  assign pick_w   = take_l ? wt_rd0_q : wt_rd1_q;
  assign msum     = {1'b0, wa_q} + {1'b0, wb_q};
  assign last_k   = {n_q, 1'b0} - (NODE_W+1)'(2);
  assign bsum     = LEN_W'(pos_q) + cl_rd_q;
  assign comp     = bsum[LEN_W-1:3];
  assign bneed    = {1'b0, bout_q} + 33'(comp);
  assign tsum     = {1'b0, tot_q} + 33'(cl_rd_q);
  assign enc_ok   = cv_rd_q && (bneed <= {2'b0, limit_q});
  assign flush_err = ({1'b0, bout_q} >= {2'b0, limit_q});
  assign bi_m1    = bi_q - LEN_W'(1);

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (req_type_i)
            REQ_COUNT: st_d = S_CNT_RD;
            REQ_BUILD: st_d = S_SRT_RD;
            REQ_LIST:  st_d = S_LST_RD;
            REQ_ENC:   st_d = S_ENC_RD;
            REQ_FLUSH: begin
              if (pos_q == '0) st_d = S_FLU_TOT;
              else if (flush_err) st_d = S_RES;
              else st_d = S_FLU_BYTE;
            end
            default:   st_d = S_IDLE;
          endcase
        end
      end
      S_CNT_RD:  st_d = S_CNT_WR;
      S_CNT_WR:  st_d = S_IDLE;
      S_SRT_RD:  st_d = S_SRT_CHK;
      S_SRT_CHK: begin
        if (hval != '0) st_d = S_SH_RD;
        else if (s_q == '1) st_d = S_SRT_END;
        else st_d = S_SRT_RD;
      end
      S_SH_RD:   st_d = (j_q == '0) ? S_SH_PUT : S_SH_CMP;
      S_SH_CMP:  st_d = (wt_rd0_q > h_q) ? S_SH_RD : S_SH_PUT;
      S_SH_PUT:  st_d = (s_q == '1) ? S_SRT_END : S_SRT_RD;
      S_SRT_END: begin
        if (n_q == '0) st_d = S_RES;
        else if (n_q == NODE_W'(1)) st_d = S_FL_RD;
        else st_d = S_MG_RD;
      end
      S_MG_RD:   st_d = S_MG_PICK;
      S_MG_PICK: st_d = second_q ? S_MG_WR : S_MG_RD;
      S_MG_WR:   st_d = ({1'b0, k_q} == last_k) ? S_CG_ROOT : S_MG_RD;
      S_CG_ROOT: st_d = S_CG_RD;
      S_CG_RD:   st_d = S_CG_W0;
      S_CG_W0:   st_d = S_CG_W1;
      S_CG_W1:   st_d = (i_q == n_q) ? S_FL_RD : S_CG_RD;
      S_FL_RD:   st_d = S_FL_CHK;
      S_FL_CHK: begin
        if (nl_rd_q > DEPTH_W'(LEN_LIMIT)) st_d = S_RES;
        else if (i_q == n_q - NODE_W'(1)) st_d = S_RES;
        else st_d = S_FL_RD;
      end
      S_LST_RD:  st_d = (!built_q || cur_q >= n_q) ? S_RES : S_LST_OUT;
      S_LST_OUT: st_d = out_free ? S_IDLE : S_LST_OUT;
      S_ENC_RD:  st_d = built_q ? S_ENC_CHK : S_RES;
      S_ENC_CHK: st_d = enc_ok ? S_ENC_BIT : S_RES;
      S_ENC_BIT: begin
        if (pos_q == 3'd7) st_d = S_ENC_EMIT;
        else if (bi_q == LEN_W'(1)) st_d = S_IDLE;
      end
      S_ENC_EMIT: if (out_free) st_d = (bi_q == '0) ? S_IDLE : S_ENC_BIT;
      S_FLU_BYTE: if (out_free) st_d = S_FLU_TOT;
      S_FLU_TOT:  if (out_free) st_d = S_IDLE;
      S_RES:      if (out_free) st_d = S_IDLE;
      default:    st_d = S_IDLE;
    endcase
  end

  // memory controls and emit requests
  always_comb begin
    hist_ra = byte_q;  hist_we = 1'b0;  hist_wd = '0;
    wt_ra0 = '0;  wt_ra1 = mq_q;  wt_we = 1'b0;  wt_wa = {1'b0, j_q};  wt_wd = h_q;
    sym_ra = '0;  sym_we = 1'b0;  sym_wa = j_q;  sym_wd = s_q;
    kid_ra = i_q;  kid_we = 1'b0;
    nc_ra = i_q;  nc_we = 1'b0;  nc_wa = '0;  nc_wd = '0;  nl_wd = '0;
    cb_we = 1'b0;  cv_clr = 1'b0;
    emit = 1'b0;  e_kind = KIND_ERR;  e_sym = '0;  e_word = '0;  e_last = 1'b1;
    unique case (st_q)
      S_IDLE: cv_clr = in_acc && (req_type_i == REQ_BUILD);
      S_CNT_WR: begin
        hist_we = 1'b1;
        hist_wd = (hval == '1) ? hval : hval + COUNT_W'(1);
      end
      S_SRT_RD: hist_ra = s_q;
      S_SH_RD: begin
        wt_ra0 = {1'b0, j_q} - NODE_W'(1);
        sym_ra = j_q - SYM_W'(1);
      end
      S_SH_CMP: begin
        if (wt_rd0_q > h_q) begin
          wt_we = 1'b1;  wt_wd = wt_rd0_q;
          sym_we = 1'b1; sym_wd = sym_rd_q;
        end
      end
      S_SH_PUT: begin
        wt_we = 1'b1;
        sym_we = 1'b1;
      end
      S_SRT_END: begin
        nc_we = (n_q == NODE_W'(1));
        nl_wd = DEPTH_W'(1);
      end
      S_MG_RD: wt_ra0 = lq_q;
      S_MG_WR: begin
        wt_we = 1'b1;  wt_wa = k_q;
        wt_wd = msum[32] ? '1 : msum[31:0];
        kid_we = 1'b1;
      end
      S_CG_ROOT: begin
        nc_we = 1'b1;  nc_wa = k_q - NODE_W'(1);
      end
      S_CG_W0: begin
        nc_we = 1'b1;  nc_wa = kid_rd_q[2*NODE_W-1:NODE_W];
        nc_wd = {nc_rd_q[MAX_CODE_LEN-2:0], 1'b0};
        nl_wd = nl_rd_q + DEPTH_W'(1);
      end
      S_CG_W1: begin
        nc_we = 1'b1;  nc_wa = kid_rd_q[NODE_W-1:0];
        nc_wd = {nc_rd_q[MAX_CODE_LEN-2:0], 1'b1};
        nl_wd = nl_rd_q + DEPTH_W'(1);
      end
      S_FL_RD: sym_ra = i_q[SYM_W-1:0];
      S_FL_CHK: begin
        if (nl_rd_q > DEPTH_W'(LEN_LIMIT)) cv_clr = 1'b1;
        else cb_we = 1'b1;
      end
      S_LST_RD: begin
        sym_ra = cur_q[SYM_W-1:0];
        wt_ra0 = cur_q;
      end
      S_LST_OUT: begin
        // keep reading the entry so a stalled output still sees it
        sym_ra = cur_q[SYM_W-1:0];
        wt_ra0 = cur_q;
        emit = 1'b1;  e_kind = KIND_LIST;  e_sym = sym_rd_q;  e_word = wt_rd0_q;
      end
      S_ENC_EMIT: begin
        emit = 1'b1;  e_kind = KIND_BYTE;  e_word = {24'b0, acc_q};
        e_last = (ecomp_q == 3'd1);
      end
      S_FLU_BYTE: begin
        emit = 1'b1;  e_kind = KIND_BYTE;  e_word = {24'b0, acc_q};  e_last = 1'b0;
      end
      S_FLU_TOT: begin
        emit = 1'b1;  e_kind = KIND_TOTAL;  e_word = tot_q;
      end
      S_RES: begin
        emit = 1'b1;  e_kind = rk_q;  e_word = rw_q;
      end
      default: ;
    endcase
  end

  // memory arrays, written and read at one edge
  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[byte_q] <= hist_wd;
    hist_rd_q <= hist_mem[hist_ra];
    if (wt_we) wt_mem[wt_wa] <= wt_wd;
    wt_rd0_q <= wt_mem[wt_ra0];
    wt_rd1_q <= wt_mem[wt_ra1];
    if (sym_we) sym_mem[sym_wa] <= sym_wd;
    sym_rd_q <= sym_mem[sym_ra];
    if (kid_we) kid_mem[k_q] <= {a_q, b_q};
    kid_rd_q <= kid_mem[kid_ra];
    if (nc_we) begin
      nc_mem[nc_wa] <= nc_wd;
      nl_mem[nc_wa] <= nl_wd;
    end
    nc_rd_q <= nc_mem[nc_ra];
    nl_rd_q <= nl_mem[nc_ra];
    if (cb_we) begin
      cb_mem[sym_rd_q] <= nc_rd_q;
      cl_mem[sym_rd_q] <= nl_rd_q[LEN_W-1:0];
    end
    cb_rd_q <= cb_mem[byte_q];
    cl_rd_q <= cl_mem[byte_q];
  end

  // valid bits of histogram and code table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q       <= '0;
      cv_q       <= '0;
      hist_hit_q <= 1'b0;
      cv_rd_q    <= 1'b0;
    end else begin
      if (hist_we) hv_q[byte_q] <= 1'b1;
      if (cv_clr) cv_q <= '0;
      else if (cb_we) cv_q[sym_rd_q] <= 1'b1;
      hist_hit_q <= hv_q[hist_ra];
      cv_rd_q    <= cv_q[byte_q];
    end
  end

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= '1;
    else if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_data_i;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (emit && out_free) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && out_free) begin
      kind_o   <= e_kind;
      symbol_o <= e_sym;
      word_o   <= e_word;
      last_o   <= e_last;
    end
  end

  assign out_valid_o = ov_q;

  // sequencer state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      built_q  <= 1'b0;
      cur_q    <= '0;
      n_q      <= '0;
      acc_q    <= '0;
      pos_q    <= '0;
      tot_q    <= '0;
      bout_q   <= '0;
      second_q <= 1'b0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        S_IDLE: begin
          if (in_acc) begin
            byte_q <= in_byte_i;
            if (req_type_i == REQ_BUILD) begin
              s_q <= '0;  n_q <= '0;  built_q <= 1'b0;  cur_q <= '0;
              acc_q <= '0;  pos_q <= '0;  tot_q <= '0;  bout_q <= '0;
            end
            rk_q <= KIND_ERR;
            rw_q <= '0;
          end
        end
        S_SRT_CHK: begin
          if (hval != '0) begin
            h_q <= hval;
            j_q <= n_q[SYM_W-1:0];
          end else begin
            s_q <= s_q + SYM_W'(1);
          end
        end
        S_SH_CMP: if (wt_rd0_q > h_q) j_q <= j_q - SYM_W'(1);
        S_SH_PUT: begin
          n_q <= n_q + NODE_W'(1);
          s_q <= s_q + SYM_W'(1);
        end
        S_SRT_END: begin
          lq_q <= '0;  mq_q <= n_q;  k_q <= n_q;  second_q <= 1'b0;  i_q <= '0;
        end
        S_MG_PICK: begin
          if (take_l) lq_q <= lq_q + NODE_W'(1);
          else mq_q <= mq_q + NODE_W'(1);
          if (!second_q) begin
            a_q <= pick_idx;  wa_q <= pick_w;  second_q <= 1'b1;
          end else begin
            b_q <= pick_idx;  wb_q <= pick_w;
          end
        end
        S_MG_WR: begin
          k_q <= k_q + NODE_W'(1);
          second_q <= 1'b0;
        end
        S_CG_ROOT: i_q <= k_q - NODE_W'(1);
        S_CG_W1:   i_q <= (i_q == n_q) ? '0 : i_q - NODE_W'(1);
        S_FL_CHK: begin
          if (nl_rd_q <= DEPTH_W'(LEN_LIMIT)) begin
            if (i_q == n_q - NODE_W'(1)) begin
              built_q <= 1'b1;
              rk_q    <= KIND_LIST;
              rw_q    <= 32'(n_q);
            end
            i_q <= i_q + NODE_W'(1);
          end
        end
        S_LST_OUT: if (out_free) cur_q <= cur_q + NODE_W'(1);
        S_ENC_CHK: begin
          if (enc_ok) begin
            ecode_q <= cb_rd_q;
            bi_q    <= cl_rd_q;
            ecomp_q <= comp;
            tot_q   <= tsum[32] ? '1 : tsum[31:0];
          end
        end
        S_ENC_BIT: begin
          if (ecode_q[bi_m1]) acc_q <= acc_q | (8'h80 >> pos_q);
          pos_q <= pos_q + 3'd1;
          bi_q  <= bi_m1;
        end
        S_ENC_EMIT: begin
          if (out_free) begin
            acc_q   <= '0;
            ecomp_q <= ecomp_q - 3'd1;
            bout_q  <= bout_q + 32'd1;
          end
        end
        S_FLU_TOT: begin
          if (out_free) begin
            acc_q <= '0;  pos_q <= '0;  tot_q <= '0;  bout_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/hbe_port_check.sv */
// hbe_port_check: port-level checks of huffman_build_and_encode results
// bound to the top level below; uses hbe_pkg
module hbe_port_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  symbol_o,
  input logic [31:0] word_o,
  input logic        last_o
);
  import hbe_pkg::*;

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(word_o) && $stable(kind_o))
    else $error("stalled output word changed");

  // error words are empty and close the request
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ERR |-> word_o == '0 && symbol_o == '0 && last_o)
    else $error("malformed error word");

  // total bit count always ends a flush
  a_tot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_TOTAL |-> last_o)
    else $error("total bits not last");

  // only list entries carry a symbol, code bytes stay in eight bits
  a_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_BYTE |-> symbol_o == '0 && word_o[31:8] == '0)
    else $error("malformed code byte word");

endmodule

bind huffman_build_and_encode hbe_port_check u_hbe_port_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .symbol_o    (symbol_o),
  .word_o      (word_o),
  .last_o      (last_o)
);
